// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, switched off while reset is high.
`define CHK_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define CHK_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== rtl/core/i2cms_pkg.sv =====
// Shared types, command codes and phase counts of the I2C bit sequencer.
package i2cms_pkg;

  // Command codes on the input stream
  localparam logic [2:0] CMD_START   = 3'd0;
  localparam logic [2:0] CMD_STOP    = 3'd1;
  localparam logic [2:0] CMD_TX_BYTE = 3'd2;
  localparam logic [2:0] CMD_RX_BYTE = 3'd3;
  localparam logic [2:0] CMD_TX_ACK  = 3'd4;
  localparam logic [2:0] CMD_RX_ACK  = 3'd5;

  // Phase counter width and index of the final phase for each command
  localparam int PHASE_W = 5;
  localparam logic [PHASE_W-1:0] SEND_LAST  = PHASE_W'(25);
  localparam logic [PHASE_W-1:0] RECV_LAST  = PHASE_W'(18);
  localparam logic [PHASE_W-1:0] SHORT_LAST = PHASE_W'(3);

  // Default depth of the command queue (power of two, at least 2)
  localparam int QDEPTH_DEF = 2;

  // Decoded command kind, one-hot
  typedef enum logic [5:0] {
    K_START   = 6'b000001,
    K_STOP    = 6'b000010,
    K_TX_BYTE = 6'b000100,
    K_RX_BYTE = 6'b001000,
    K_TX_ACK  = 6'b010000,
    K_RX_ACK  = 6'b100000
  } kind_t;

  // One queued command
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic        ack;
    logic [7:0]  levels;
  } item_t;

  // Queue head as seen by the sequencer
  typedef struct packed {
    logic  valid;
    item_t item;
  } link_t;

  // Decode a command code; codes past receive ack are flagged invalid
  function automatic logic [6:0] classify(input logic [2:0] cmd);
    logic [6:0] res;
    res = {1'b1, K_START};
    case (cmd)
      CMD_START:   res = {1'b1, K_START};
      CMD_STOP:    res = {1'b1, K_STOP};
      CMD_TX_BYTE: res = {1'b1, K_TX_BYTE};
      CMD_RX_BYTE: res = {1'b1, K_RX_BYTE};
      CMD_TX_ACK:  res = {1'b1, K_TX_ACK};
      CMD_RX_ACK:  res = {1'b1, K_RX_ACK};
      default:     res = {1'b0, K_START};
    endcase
    return res;
  endfunction

  // Index of the final phase of a command
  function automatic logic [PHASE_W-1:0] last_phase(input kind_t kind);
    logic [PHASE_W-1:0] res;
    res = SHORT_LAST;
    case (kind)
      K_TX_BYTE: res = SEND_LAST;
      K_RX_BYTE: res = RECV_LAST;
      default:   res = SHORT_LAST;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/core/i2c_master_bit_sequencer_core.sv =====
// Top level of the I2C master bit sequencer: command queue and phase sequencer.
//
//  channel  | dir | tdata fields (low bit up)                          | tlast
//  s_*      | in  | command[2:0] data_byte[10:3] ack_value[11]          | -
//           |     | bus_levels[19:12], zero to 23                      |
//  m_*      | out | scl_level[0] sda_level[1] read_byte[9:2]           | last
//           |     | ack_seen[10], zero to 15                           |
//
//  One pin phase per cycle unless m_tready stalls: start, stop and the ack
//  commands have 4 phases, receive byte 19, send byte 26, per the phase counter.
//  Unknown command codes are taken in and dropped without results.
//  Synchronous reset empties the queue and releases both lines high.
//  A stalled m_tready holds the sequencer; the queue keeps taking commands
//  until its QDEPTH entries are full.
module i2c_master_bit_sequencer_core #(
  parameter int QDEPTH = i2cms_pkg::QDEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // command, data_byte, ack_value, bus_levels
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // scl_level, sda_level, read_byte, ack_seen
  output logic        m_tlast
);

  i2cms_pkg::link_t head;
  logic             pop;

  // Intake and queue
  i2cms_front #(
    .QDEPTH (QDEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .command    (s_tdata[2:0]),
    .data_byte  (s_tdata[10:3]),
    .ack_value  (s_tdata[11]),
    .bus_levels (s_tdata[19:12]),
    .head       (head),
    .pop        (pop)
  );

  // Phase sequencer and output register
  i2cms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

// ===== rtl/core/i2cms_front.sv =====
// Command intake: decodes commands, drops unknown codes, queues the rest.
module i2cms_front #(
  parameter int QDEPTH = i2cms_pkg::QDEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           command,
  input  logic [7:0]           data_byte,
  input  logic                 ack_value,
  input  logic [7:0]           bus_levels,
  output i2cms_pkg::link_t     head,
  input  logic                 pop
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  i2cms_pkg::item_t   entries [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic [6:0]         decoded;
  logic               push;
  logic               do_pop;
  i2cms_pkg::item_t   new_item;

  // Decode
  assign decoded = i2cms_pkg::classify(command);
  assign new_item.kind   = i2cms_pkg::kind_t'(decoded[5:0]);
  assign new_item.data   = data_byte;
  assign new_item.ack    = ack_value;
  assign new_item.levels = bus_levels;

  assign in_ready = (count != CNT_W'(QDEPTH));
  assign push     = in_valid && in_ready && decoded[6];
  assign do_pop   = pop && (count != '0);

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= new_item;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assign head.valid = (count != '0);
  assign head.item  = entries[rd_ptr];

endmodule

// ===== rtl/core/i2cms_back.sv =====
// Phase sequencer: steps each queued command through its pin phases.
module i2cms_back (
  input  logic              clk,
  input  logic              rst,
  input  i2cms_pkg::link_t  head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_data,
  output logic              out_last
);

  localparam int PW = i2cms_pkg::PHASE_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t             state;
  i2cms_pkg::item_t   cur;
  logic [7:0]         shreg;
  logic [PW-1:0]      phase;
  logic [1:0]         sub;
  logic               scl;
  logic               sda;

  logic               adv;
  logic               emit;
  logic               lst;
  logic               mid;
  logic               scl_next;
  logic               sda_next;
  logic [7:0]         rb;
  logic               ak;

  assign adv  = !out_valid || out_ready;
  assign emit = (state == ST_RUN) && adv;
  assign lst  = (phase == i2cms_pkg::last_phase(cur.kind));
  assign mid  = (phase != '0) && (phase != i2cms_pkg::SEND_LAST);
  assign pop  = head.valid && ((state == ST_IDLE) || (emit && lst));

  // Pin levels for the current phase
  always_comb begin
    scl_next = scl;
    sda_next = sda;
    rb       = '0;
    ak       = 1'b0;
    case (cur.kind)
      i2cms_pkg::K_START: begin
        case (phase[1:0])
          2'd0:    scl_next = 1'b1;
          2'd1:    sda_next = 1'b1;
          2'd2:    sda_next = 1'b0;
          default: scl_next = 1'b0;
        endcase
      end
      i2cms_pkg::K_STOP: begin
        case (phase[1:0])
          2'd0:    scl_next = 1'b0;
          2'd1:    sda_next = 1'b0;
          2'd2:    scl_next = 1'b1;
          default: sda_next = 1'b1;
        endcase
      end
      i2cms_pkg::K_TX_ACK: begin
        case (phase[1:0])
          2'd0:    scl_next = 1'b0;
          2'd1:    sda_next = cur.ack;
          2'd2:    scl_next = 1'b1;
          default: scl_next = 1'b0;
        endcase
      end
      i2cms_pkg::K_RX_ACK: begin
        case (phase[1:0])
          2'd0:    sda_next = 1'b1;
          2'd1:    scl_next = 1'b0;
          2'd2:    scl_next = 1'b1;
          default: begin
            scl_next = 1'b0;
            ak       = cur.levels[7];
          end
        endcase
      end
      i2cms_pkg::K_TX_BYTE: begin
        if (!mid) begin
          scl_next = 1'b0;
        end else begin
          case (sub)
            2'd0:    sda_next = shreg[7];
            2'd1:    scl_next = 1'b1;
            default: scl_next = 1'b0;
          endcase
        end
      end
      i2cms_pkg::K_RX_BYTE: begin
        // SDA is released throughout, so a sample is the bus level itself
        if (phase == '0) begin
          sda_next = 1'b1;
        end else if (phase == PW'(1)) begin
          scl_next = 1'b0;
        end else if (phase == i2cms_pkg::RECV_LAST) begin
          scl_next = 1'b0;
          rb       = cur.levels;
        end else begin
          scl_next = !phase[0];
        end
      end
      default: begin
        scl_next = scl;
      end
    endcase
  end

  // Sequencer control and line state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= '0;
      sub   <= '0;
      scl   <= 1'b1;
      sda   <= 1'b1;
    end else begin
      if (emit) begin
        scl <= scl_next;
        sda <= sda_next;
      end
      if (pop) begin
        state <= ST_RUN;
        phase <= '0;
        sub   <= '0;
      end else if (emit) begin
        phase <= phase + PW'(1);
        if ((cur.kind == i2cms_pkg::K_TX_BYTE) && mid) begin
          sub <= (sub == 2'd2) ? 2'd0 : sub + 2'd1;
        end
        if (lst) begin
          state <= ST_IDLE;
        end
      end
    end
  end

  // Current command and transmit shifter
  always_ff @(posedge clk) begin
    if (pop) begin
      cur   <= head.item;
      shreg <= head.item.data;
    end else if (emit && (cur.kind == i2cms_pkg::K_TX_BYTE) && mid && (sub == 2'd2)) begin
      shreg <= {shreg[6:0], 1'b0};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= {5'b0, ak, rb, sda_next, scl_next};
      out_last <= lst;
    end
  end

endmodule

// ===== rtl/core/i2cms_checker.sv =====
// Port-level checks for the I2C bit sequencer, bound to the top level.
`include "assert_macros.svh"

module i2cms_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [23:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);

  logic prev_scl;
  logic prev_sda;
  logic scl_moved;
  logic sda_moved;

  // Line levels of the last delivered transaction, idle high after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_scl <= 1'b1;
      prev_sda <= 1'b1;
    end else if (m_tvalid && m_tready) begin
      prev_scl <= m_tdata[0];
      prev_sda <= m_tdata[1];
    end
  end

  assign scl_moved = (m_tdata[0] != prev_scl);
  assign sda_moved = (m_tdata[1] != prev_sda);

  `CHK_ASSERT_ALWAYS(a_rst_quiet, clk, rst |=> !m_tvalid, "output valid after reset")
  `CHK_ASSERT(a_in_hold, clk, rst, s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata), "in held")
  `CHK_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled output changed")
  `CHK_ASSERT(a_one_line, clk, rst, m_tvalid && m_tready |-> !(scl_moved && sda_moved), "both lines moved in one phase")
  `CHK_ASSERT(a_rx_on_last, clk, rst, m_tvalid && !m_tlast |-> m_tdata[10:2] == 9'd0, "receive data before final phase")

endmodule

bind i2c_master_bit_sequencer_core i2cms_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
